// ===== src/alm_pkg.sv =====
`default_nettype none
package alm_pkg;
    localparam int unsigned CAPACITY = 256;
    localparam int unsigned SW = 9;
    localparam int unsigned DEPTH = CAPACITY + 1;

    typedef logic [SW-1:0] slot_t;

    typedef enum logic [2:0] {
        MODE_INS_AFTER  = 3'd0,
        MODE_INS_BEFORE = 3'd1,
        MODE_REMOVE     = 3'd2,
        MODE_FIND       = 3'd3,
        MODE_LOOKUP     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic     rd_en;
        slot_t    rd_addr;
        logic     nx_we;
        slot_t    nx_addr;
        slot_t    nx_data;
        logic     pv_we;
        slot_t    pv_addr;
        slot_t    pv_data;
        logic     fr_we;
        slot_t    fr_addr;
        logic     fr_data;
        logic     kd_we;
        slot_t    kd_addr;
    } dp_cmd_t;

    // Datapath to controller (registered reads at rd_addr).
    typedef struct packed {
        slot_t       nx_q;
        slot_t       pv_q;
        logic        fr_q;
        logic        key_hit;
    } dp_stat_t;

    function automatic slot_t lim(input slot_t x);
        lim = (x <= slot_t'(CAPACITY)) ? x : '0;
    endfunction
endpackage
`default_nettype wire

// ===== src/alm_datapath.sv =====
`default_nettype none
module alm_datapath
    import alm_pkg::*;
(
    input  wire logic         clk,
    input  wire dp_cmd_t      cmd,
    input  wire logic [63:0]  wr_key,
    input  wire logic [31:0]  wr_data,
    input  wire logic [63:0]  cmp_key,
    output dp_stat_t          stat,
    output logic [63:0]       rd_key,
    output logic [31:0]       rd_data
);
    slot_t       next_mem [DEPTH];
    slot_t       prev_mem [DEPTH];
    logic        free_mem [DEPTH];
    logic [63:0] key_mem  [DEPTH];
    logic [31:0] data_mem [DEPTH];

    slot_t       nx_q_reg;
    slot_t       pv_q_reg;
    logic        fr_q_reg;
    logic [63:0] key_q_reg;
    logic [31:0] data_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.nx_we)
        begin
            next_mem[cmd.nx_addr] <= cmd.nx_data;
        end
        if (cmd.rd_en)
        begin
            nx_q_reg <= next_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pv_we)
        begin
            prev_mem[cmd.pv_addr] <= cmd.pv_data;
        end
        if (cmd.rd_en)
        begin
            pv_q_reg <= prev_mem[cmd.rd_addr];
        end
    end

    // Free marks share their port with the reset sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.fr_we)
        begin
            free_mem[cmd.fr_addr] <= cmd.fr_data;
        end
        if (cmd.rd_en)
        begin
            fr_q_reg <= free_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.kd_we)
        begin
            key_mem[cmd.kd_addr]  <= wr_key;
            data_mem[cmd.kd_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            key_q_reg  <= key_mem[cmd.rd_addr];
            data_q_reg <= data_mem[cmd.rd_addr];
        end
    end

    assign stat.nx_q    = nx_q_reg;
    assign stat.pv_q    = pv_q_reg;
    assign stat.fr_q    = fr_q_reg;
    assign stat.key_hit = (key_q_reg == cmp_key);
    assign rd_key       = key_q_reg;
    assign rd_data      = data_q_reg;
endmodule
`default_nettype wire

// ===== src/alm_ctrl.sv =====
`default_nettype none
module alm_ctrl
    import alm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire slot_t       position,
    output logic             out_valid,
    input  wire logic        out_ready,
    output status_t          res_status,
    output slot_t            res_slot,
    output logic             res_take_kd,
    output dp_cmd_t          cmd,
    input  wire dp_stat_t    stat
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_P, S_DECIDE, S_RD_N, S_FIX,
        S_WALK_RD, S_WALK_CHK, S_DONE
    } state_t;

    state_t  state_reg, state_next;
    logic [2:0] mode_reg, mode_next;
    slot_t   pos_reg, pos_next;
    slot_t   head_reg, head_next;
    slot_t   tail_reg, tail_next;
    slot_t   fhead_reg, fhead_next;
    slot_t   count_reg, count_next;
    logic    order_reg, order_next;
    slot_t   cur_reg, cur_next;     // walk pointer / new slot
    slot_t   idx_reg, idx_next;     // walk step count
    slot_t   aux_reg, aux_next;     // neighbour awaiting link fix
    logic    aux_prev_reg, aux_prev_next;
    status_t st_reg, st_next;
    slot_t   slot_reg, slot_next;
    logic    kd_reg, kd_next;
    logic    ov_reg, ov_next;
    slot_t   clr_reg, clr_next;
    dp_cmd_t c;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign res_status  = st_reg;
    assign res_slot    = slot_reg;
    assign res_take_kd = kd_reg;
    assign cmd         = c;

    always_comb
    begin
        state_next = state_reg; mode_next = mode_reg; pos_next = pos_reg;
        head_next = head_reg; tail_next = tail_reg; fhead_next = fhead_reg;
        count_next = count_reg; order_next = order_reg; cur_next = cur_reg;
        idx_next = idx_reg; aux_next = aux_reg; aux_prev_next = aux_prev_reg;
        st_next = st_reg; slot_next = slot_reg; kd_next = kd_reg;
        ov_next = ov_reg; clr_next = clr_reg;
        c = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                c.nx_we   = 1'b1;
                c.nx_addr = clr_reg;
                c.nx_data = (clr_reg != '0 && clr_reg < slot_t'(CAPACITY))
                            ? clr_reg + slot_t'(1) : '0;
                c.pv_we   = 1'b1;
                c.pv_addr = clr_reg;
                c.fr_we   = 1'b1;
                c.fr_addr = clr_reg;
                c.fr_data = (clr_reg != '0);
                if (clr_reg == slot_t'(CAPACITY))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + slot_t'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    pos_next  = position;
                    kd_next   = 1'b0;
                    st_next   = ST_BAD_POS;
                    slot_next = '0;
                    priority if (mode == MODE_FIND)
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_MISSING; state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next = lim(head_reg); idx_next = '0;
                            state_next = S_WALK_RD;
                        end
                    end
                    else if (mode == MODE_LOOKUP)
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_MISSING; state_next = S_DONE;
                        end
                        else if (position == '0 || position > count_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else if (order_reg)
                        begin
                            st_next = ST_OK;
                            slot_next = lim(slot_t'(head_reg + position - slot_t'(1)));
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next = lim(head_reg); idx_next = slot_t'(1);
                            state_next = S_WALK_RD;
                        end
                    end
                    else if (mode <= MODE_REMOVE && position != '0
                             && position <= slot_t'(CAPACITY))
                    begin
                        c.rd_en = 1'b1; c.rd_addr = position;
                        state_next = S_DECIDE;
                    end
                    else if (mode == MODE_REMOVE && count_reg == '0)
                    begin
                        st_next = ST_MISSING; state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RD_P:
            begin
                c.rd_en = 1'b1; c.rd_addr = pos_reg;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // stat holds next, prev and free of pos_reg
                state_next = S_DONE;
                if (mode_reg == MODE_REMOVE)
                begin
                    if (count_reg == '0) st_next = ST_MISSING;
                    else if (stat.fr_q) st_next = ST_BAD_POS;
                    else
                    begin
                        st_next = ST_OK; slot_next = pos_reg; kd_next = 1'b1;
                        c.fr_we = 1'b1; c.fr_addr = pos_reg; c.fr_data = 1'b1;
                        c.pv_we = 1'b1; c.pv_addr = pos_reg; c.pv_data = '0;
                        c.nx_we = 1'b1; c.nx_addr = pos_reg; c.nx_data = fhead_reg;
                        fhead_next = pos_reg;
                        count_next = count_reg - slot_t'(1);
                        if (pos_reg == head_reg && pos_reg == tail_reg)
                        begin
                        end
                        else if (pos_reg == head_reg)
                        begin
                            head_next = lim(stat.nx_q);
                            aux_next = lim(stat.nx_q); aux_prev_next = 1'b1;
                            cur_next = '0; state_next = S_FIX;
                        end
                        else if (pos_reg == tail_reg)
                        begin
                            tail_next = lim(stat.pv_q);
                            aux_next = lim(stat.pv_q); aux_prev_next = 1'b0;
                            cur_next = '0; state_next = S_FIX;
                        end
                        else
                        begin
                            order_next = 1'b0;
                            // next of v and prev of n (via aux) are both fixed in S_RD_N
                            aux_next = lim(stat.nx_q); aux_prev_next = 1'b1;
                            cur_next = lim(stat.pv_q);
                            idx_next = lim(stat.nx_q);
                            state_next = S_RD_N;
                        end
                    end
                end
                else if (mode_reg == MODE_INS_BEFORE && count_reg != '0)
                begin
                    if (stat.fr_q) st_next = ST_BAD_POS;
                    else if (fhead_reg == '0) st_next = ST_FULL;
                    else if (pos_reg != head_reg)
                    begin
                        mode_next = MODE_INS_AFTER;
                        pos_next = lim(stat.pv_q);
                        if (lim(stat.pv_q) == '0) st_next = ST_BAD_POS;
                        else state_next = S_RD_P;
                    end
                    else
                    begin
                        if (head_reg != fhead_reg + slot_t'(1)) order_next = 1'b0;
                        c.rd_en = 1'b1; c.rd_addr = fhead_reg;
                        c.kd_we = 1'b1; c.kd_addr = fhead_reg;
                        c.fr_we = 1'b1; c.fr_addr = fhead_reg; c.fr_data = 1'b0;
                        c.nx_we = 1'b1; c.nx_addr = fhead_reg; c.nx_data = head_reg;
                        c.pv_we = 1'b1; c.pv_addr = head_reg; c.pv_data = fhead_reg;
                        cur_next = fhead_reg; head_next = fhead_reg;
                        count_next = count_reg + slot_t'(1);
                        st_next = ST_OK; slot_next = fhead_reg;
                        aux_next = '0;
                        state_next = S_RD_N;
                    end
                end
                else
                begin
                    // insert after (or before on an empty list)
                    if (stat.fr_q && (count_reg != '0 || pos_reg != tail_reg))
                        st_next = ST_BAD_POS;
                    else if (fhead_reg == '0) st_next = ST_FULL;
                    else
                    begin
                        if (pos_reg != tail_reg) order_next = 1'b0;
                        c.rd_en = 1'b1; c.rd_addr = fhead_reg;
                        c.kd_we = 1'b1; c.kd_addr = fhead_reg;
                        c.fr_we = 1'b1; c.fr_addr = fhead_reg; c.fr_data = 1'b0;
                        cur_next = fhead_reg;
                        count_next = count_reg + slot_t'(1);
                        st_next = ST_OK; slot_next = fhead_reg;
                        if (count_reg == '0)
                        begin
                            c.pv_we = 1'b1; c.pv_addr = fhead_reg; c.pv_data = '0;
                            head_next = fhead_reg; tail_next = fhead_reg;
                            aux_next = '0;
                        end
                        else if (pos_reg == tail_reg)
                        begin
                            if (fhead_reg != tail_reg + slot_t'(1)) order_next = 1'b0;
                            c.pv_we = 1'b1; c.pv_addr = fhead_reg; c.pv_data = tail_reg;
                            c.nx_we = 1'b1; c.nx_addr = tail_reg; c.nx_data = fhead_reg;
                            tail_next = fhead_reg;
                            aux_next = '0;
                        end
                        else
                        begin
                            c.pv_we = 1'b1; c.pv_addr = fhead_reg; c.pv_data = pos_reg;
                            c.nx_we = 1'b1; c.nx_addr = pos_reg; c.nx_data = fhead_reg;
                            aux_next = lim(stat.nx_q);  // n, may be 0
                        end
                        state_next = S_RD_N;
                    end
                end
            end
            S_RD_N:
            begin
                // inserts: stat.nx_q is next of the taken slot
                state_next = S_DONE;
                if (mode_reg == MODE_REMOVE)
                begin
                    if (cur_reg != '0)
                    begin
                        c.nx_we = 1'b1; c.nx_addr = cur_reg; c.nx_data = idx_reg;
                    end
                    if (aux_reg != '0)
                    begin
                        c.pv_we = 1'b1; c.pv_addr = aux_reg; c.pv_data = cur_reg;
                    end
                end
                else
                begin
                    fhead_next = lim(stat.nx_q);
                    if (mode_reg == MODE_INS_BEFORE && count_reg != slot_t'(1))
                    begin
                        c.pv_we = 1'b1; c.pv_addr = cur_reg; c.pv_data = '0;
                    end
                    else
                    begin
                        c.nx_we = 1'b1; c.nx_addr = cur_reg; c.nx_data = aux_reg;
                        if (aux_reg != '0)
                        begin
                            c.pv_we = 1'b1; c.pv_addr = aux_reg; c.pv_data = cur_reg;
                        end
                    end
                end
            end
            S_FIX:
            begin
                if (aux_prev_reg)
                begin
                    c.pv_we = 1'b1; c.pv_addr = aux_reg; c.pv_data = cur_reg;
                end
                else
                begin
                    c.nx_we = 1'b1; c.nx_addr = aux_reg; c.nx_data = cur_reg;
                end
                state_next = S_DONE;
            end
            S_WALK_RD:
            begin
                if (mode_reg == MODE_LOOKUP && idx_reg == pos_reg)
                begin
                    st_next = ST_OK; slot_next = cur_reg; state_next = S_DONE;
                end
                else if (mode_reg == MODE_FIND
                         && (idx_reg == count_reg || cur_reg == '0))
                begin
                    st_next = ST_MISSING; state_next = S_DONE;
                end
                else
                begin
                    c.rd_en = 1'b1; c.rd_addr = cur_reg;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (mode_reg == MODE_FIND && stat.key_hit)
                begin
                    st_next = ST_OK; slot_next = cur_reg; state_next = S_DONE;
                end
                else
                begin
                    cur_next = lim(stat.nx_q);
                    idx_next = idx_reg + slot_t'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    if (st_reg != ST_OK) slot_next = '0;
                end
                else if (out_ready)
                begin
                    ov_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR; clr_reg <= '0;
            head_reg <= slot_t'(1); tail_reg <= slot_t'(1); fhead_reg <= slot_t'(1);
            count_reg <= '0; order_reg <= 1'b1; ov_reg <= 1'b0;
            mode_reg <= '0; pos_reg <= '0; cur_reg <= '0; idx_reg <= '0;
            aux_reg <= '0; aux_prev_reg <= 1'b0; st_reg <= ST_OK;
            slot_reg <= '0; kd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; clr_reg <= clr_next;
            head_reg <= head_next; tail_reg <= tail_next; fhead_reg <= fhead_next;
            count_reg <= count_next; order_reg <= order_next; ov_reg <= ov_next;
            mode_reg <= mode_next; pos_reg <= pos_next; cur_reg <= cur_next;
            idx_reg <= idx_next; aux_reg <= aux_next; aux_prev_reg <= aux_prev_next;
            st_reg <= st_next; slot_reg <= slot_next; kd_reg <= kd_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/array_linked_list_manager.sv =====
// Array-backed doubly linked list manager, 256 slots numbered 1..256.
// Input channel: in_valid/in_ready carry mode, position, entry_key and
// entry_data. Output channel: out_valid/out_ready carry status, slot,
// out_key and out_data; one result item per input item.
// One item is in flight at a time; in_ready is high only while idle.
// Lookup in order and an error found before any memory read need no read;
// insert before away from the front re-reads the predecessor. Find and
// unordered lookup walk the next links through the single registered
// read port, reading each entry visited and then checking it.
// After reset the controller sweeps the link and free-mark memories, one
// slot a cycle over slots 0 to 256, with in_ready low.
// A result waits in its output register while out_ready is low; no new
// item is taken until it is delivered.
`default_nettype none
module array_linked_list_manager
    import alm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [8:0]  position,
    input  wire logic [63:0] entry_key,
    input  wire logic [31:0] entry_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [8:0]       slot,
    output logic [63:0]      out_key,
    output logic [31:0]      out_data
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    status_t     res_status;
    slot_t       res_slot;
    logic        take_kd;
    logic [63:0] key_reg;
    logic [31:0] data_reg;
    logic [63:0] rd_key;
    logic [31:0] rd_data;
    logic [63:0] okey_reg;
    logic [31:0] odata_reg;

    // Hold the item's key and data for the memory write and the compare.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg  <= entry_key;
            data_reg <= entry_data;
        end
    end

    // Capture the removed entry while its read data is still on the port.
    always_ff @(posedge clk)
    begin
        if (take_kd && !out_valid)
        begin
            okey_reg  <= rd_key;
            odata_reg <= rd_data;
        end
    end

    alm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_status (res_status),
        .res_slot   (res_slot),
        .res_take_kd(take_kd),
        .cmd        (cmd),
        .stat       (stat)
    );

    alm_datapath u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .wr_key  (key_reg),
        .wr_data (data_reg),
        .cmp_key (key_reg),
        .stat    (stat),
        .rd_key  (rd_key),
        .rd_data (rd_data)
    );

    assign status   = res_status;
    assign slot     = res_slot;
    assign out_key  = take_kd ? okey_reg : '0;
    assign out_data = take_kd ? odata_reg : '0;
endmodule
`default_nettype wire

// ===== bench/list_checker.sv =====
`default_nettype none
module list_checker
    import alm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [8:0]  position,
    input  wire logic [63:0] entry_key,
    input  wire logic [31:0] entry_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  status,
    input  wire logic [8:0]  slot,
    input  wire logic [63:0] out_key,
    input  wire logic [31:0] out_data,
    output int               fails,
    output int               pending
);
    typedef struct packed {
        status_t     st;
        slot_t       s;
        logic [63:0] k;
        logic [31:0] d;
    } outcome_t;

    // Shadow copy of the list; the bench also reads it to aim its stimulus.
    int unsigned nxt   [0:CAPACITY];
    int unsigned prv   [0:CAPACITY];
    bit          vacant[0:CAPACITY];
    logic [63:0] keys  [0:CAPACITY];
    logic [31:0] datas [0:CAPACITY];
    int unsigned front, back, spare, count;
    bit          ordered;

    outcome_t    awaited[$];

    assign pending = awaited.size();

    function automatic int unsigned bnd(input int unsigned x);
        return (x <= CAPACITY) ? x : 0;
    endfunction

    function automatic int unsigned claim(input logic [63:0] k, input logic [31:0] d);
        int unsigned s;
        s = bnd(spare);
        spare = bnd(nxt[s]);
        vacant[s] = 0;
        keys[s] = k;
        datas[s] = d;
        return s;
    endfunction

    function automatic status_t link_after(input int unsigned p, input logic [63:0] k,
                                           input logic [31:0] d, output int unsigned s);
        int unsigned n;
        s = 0;
        if (p == 0 || p > CAPACITY) return ST_BAD_POS;
        if (vacant[p] && (count != 0 || p != back)) return ST_BAD_POS;
        if (spare == 0) return ST_FULL;
        if (p != back) ordered = 0;
        if (count == 0) begin
            s = claim(k, d);
            nxt[s] = 0;
            prv[s] = 0;
            front = s;
            back = s;
        end else if (p == back) begin
            if (spare != back + 1) ordered = 0;
            s = claim(k, d);
            prv[s] = back;
            nxt[back] = s;
            nxt[s] = 0;
            back = s;
        end else begin
            ordered = 0;
            s = claim(k, d);
            n = bnd(nxt[p]);
            nxt[s] = n;
            prv[s] = p;
            nxt[p] = s;
            if (n != 0) prv[n] = s;
        end
        count++;
        return ST_OK;
    endfunction

    function automatic status_t link_before(input int unsigned p, input logic [63:0] k,
                                            input logic [31:0] d, output int unsigned s);
        s = 0;
        if (p == 0 || p > CAPACITY) return ST_BAD_POS;
        if (count == 0) return link_after(p, k, d, s);
        if (vacant[p]) return ST_BAD_POS;
        if (spare == 0) return ST_FULL;
        if (p != front) return link_after(bnd(prv[p]), k, d, s);
        if (front != spare + 1) ordered = 0;
        s = claim(k, d);
        nxt[s] = front;
        prv[s] = 0;
        prv[front] = s;
        front = s;
        count++;
        return ST_OK;
    endfunction

    function automatic void free_slot(input int unsigned p);
        vacant[p] = 1;
        prv[p] = 0;
        nxt[p] = spare;
        spare = p;
    endfunction

    function automatic outcome_t apply_op(input logic [2:0] m, input int unsigned p,
                                          input logic [63:0] k, input logic [31:0] d);
        outcome_t    r;
        int unsigned s, e, n, v;
        r = '0;
        r.st = ST_BAD_POS;
        s = 0;
        case (m)
            MODE_INS_AFTER:  r.st = link_after(p, k, d, s);
            MODE_INS_BEFORE: r.st = link_before(p, k, d, s);
            MODE_REMOVE: begin
                if (count == 0) r.st = ST_MISSING;
                else if (p == 0 || p > CAPACITY || vacant[p]) r.st = ST_BAD_POS;
                else begin
                    r.k = keys[p];
                    r.d = datas[p];
                    if (p == front && p == back) free_slot(p);
                    else if (p == front) begin
                        n = bnd(nxt[p]);
                        prv[n] = 0;
                        free_slot(p);
                        front = n;
                    end else if (p == back) begin
                        v = bnd(prv[p]);
                        nxt[v] = 0;
                        free_slot(p);
                        back = v;
                    end else begin
                        ordered = 0;
                        n = bnd(nxt[p]);
                        v = bnd(prv[p]);
                        free_slot(p);
                        if (n != 0) prv[n] = v;
                        if (v != 0) nxt[v] = n;
                    end
                    count--;
                    r.st = ST_OK;
                    s = p;
                end
            end
            MODE_FIND: begin
                r.st = ST_MISSING;
                e = bnd(front);
                for (int unsigned i = 0; i < count && e != 0; i++) begin
                    if (keys[e] == k) begin
                        r.st = ST_OK;
                        s = e;
                        break;
                    end
                    e = bnd(nxt[e]);
                end
            end
            MODE_LOOKUP: begin
                if (count == 0) r.st = ST_MISSING;
                else if (p == 0 || p > count) r.st = ST_BAD_POS;
                else begin
                    if (ordered) e = bnd(front + p - 1);
                    else begin
                        e = bnd(front);
                        for (int unsigned i = 1; i < p; i++) e = bnd(nxt[e]);
                    end
                    r.st = ST_OK;
                    s = e;
                end
            end
            default: ;
        endcase
        r.s = (r.st == ST_OK) ? slot_t'(s) : '0;
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= CAPACITY; i++) begin
                vacant[i] = (i != 0);
                nxt[i] = (i != 0 && i < CAPACITY) ? i + 1 : 0;
                prv[i] = 0;
            end
            front = 1;
            back = 1;
            spare = 1;
            count = 0;
            ordered = 1;
            awaited.delete();
        end else begin
            // Retire the delivered result before taking a new item on the same edge.
            if (out_valid && out_ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result item with nothing expected", $realtime);
                    fails++;
                end else begin
                    outcome_t w;
                    w = awaited.pop_front();
                    if (status !== w.st) report("status", status, w.st);
                    if (slot !== w.s) report("slot", slot, w.s);
                    if (out_key !== w.k) report("out_key", out_key, w.k);
                    if (out_data !== w.d) report("out_data", out_data, w.d);
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_op(mode, position, entry_key, entry_data));
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
    import alm_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [8:0]  position = '0;
    logic [63:0] entry_key = '0;
    logic [31:0] entry_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [1:0]  status;
    logic [8:0]  slot;
    logic [63:0] out_key;
    logic [31:0] out_data;
    int          fails, pending;
    bit          quiet = 0;
    int          hold = 0;

    always #5 clk = ~clk;

    array_linked_list_manager DUT (.*);

    list_checker chk (.*);

    // Receiver: stall in random bursts until the closing stretch.
    always @(negedge clk)
    begin
        if (hold > 0) begin
            hold--;
            out_ready <= 0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(0, 15);
            out_ready <= 0;
        end else
            out_ready <= 1;
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // once the shadow list has advanced.
    task automatic send(input logic [2:0] m, input int unsigned p,
                        input logic [63:0] k, input logic [31:0] d);
        in_valid = 1;
        mode = m;
        position = p[8:0];
        entry_key = k;
        entry_data = d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        // Hold valid high if the next item follows at once; drop it otherwise.
    endtask

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 16);
        @(negedge clk);
        in_valid = 0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic int unsigned used_slot();
        int unsigned p;
        for (int i = 0; i < 400; i++) begin
            p = $urandom_range(1, CAPACITY);
            if (!chk.vacant[p]) return p;
        end
        return chk.back;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item(input int ins_w, input int rem_w);
        int          r;
        int unsigned p;
        logic [63:0] k;
        r = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : used_slot();
        k = rand_key();
        if (r < ins_w)
            send(($urandom_range(0, 2) == 0) ? MODE_INS_BEFORE : MODE_INS_AFTER,
                 p, k, $urandom);
        else if (r < ins_w + rem_w)
            send(MODE_REMOVE, p, k, $urandom);
        else if (r < 88) begin
            if ($urandom_range(0, 3) != 0) k = chk.keys[used_slot()];
            send(MODE_FIND, p, chk.count == 0 ? k : k, $urandom);
        end else if (r < 97)
            send(MODE_LOOKUP, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                 : $urandom_range(0, chk.count + 1), k, $urandom);
        else
            send(3'($urandom_range(0, 7)), $urandom_range(0, 511), k, $urandom);
    endtask

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: empty list, bounds, one-entry front insert, end and mid removals.
        send(MODE_LOOKUP, 1, 0, 0);
        send(MODE_REMOVE, 1, 0, 0);
        send(MODE_FIND, 0, 0, 0);
        send(MODE_INS_AFTER, 0, 0, 0);
        send(MODE_INS_AFTER, 257, 0, 0);
        send(MODE_INS_AFTER, 511, '1, '1);
        send(MODE_INS_BEFORE, 2, 0, 0);
        send(MODE_INS_BEFORE, 1, '1, '1);
        send(MODE_INS_BEFORE, 1, 64'h5, 32'h5);
        send(MODE_INS_AFTER, chk.back, 0, 0);
        send(MODE_INS_AFTER, chk.front, 64'h77, 32'h77);
        send(MODE_INS_BEFORE, chk.back, 64'h99, 32'h99);
        send(MODE_INS_BEFORE, 100, 0, 0);
        send(MODE_REMOVE, 100, 0, 0);
        send(MODE_FIND, 0, '1, 0);
        send(MODE_FIND, 0, 64'h123, 0);
        send(MODE_LOOKUP, 0, 0, 0);
        send(MODE_LOOKUP, 200, 0, 0);
        send(MODE_LOOKUP, 3, 0, 0);
        send(MODE_REMOVE, chk.front, 0, 0);
        send(MODE_REMOVE, chk.back, 0, 0);
        send(MODE_REMOVE, chk.nxt[chk.front], 0, 0);
        send(3'd5, 511, '1, '1);
        send(3'd6, 0, 0, 0);
        send(3'd7, 256, '1, '1);

        // Fill towards a full list, then drain, then a balanced mix.
        for (int i = 0; i < 900; i++) begin
            if (i == 450) begin
                @(negedge clk);
                in_valid = 0;
                while (pending != 0) @(negedge clk);
            end
            if (i == 800) quiet = 1;
            if (!quiet && $urandom_range(0, 5) == 0) idle_burst();
            if (i < 450) random_item(80, 5);
            else if (i < 650) random_item(15, 60);
            else random_item(40, 30);
        end
        @(negedge clk);
        in_valid = 0;

        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
